/* rtl/core/gtp_pkg.sv */
// Go-to-pose controller package: types, codes, constants and the CORDIC angle table.
// Used by every file in rtl/core; depends on nothing.
package gtp_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam int POS_W  = 21;
    localparam int ANG_W  = 17;
    localparam int CFG_DW = 19;
    localparam int DIV_NW = 33;
    localparam int DIV_DW = 18;

    localparam logic [2:0] CFG_MAX_LIN    = 3'd0;
    localparam logic [2:0] CFG_MAX_TURN   = 3'd1;
    localparam logic [2:0] CFG_SPD_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_TURN_SLOPE = 3'd3;
    localparam logic [2:0] CFG_ARRIVE     = 3'd4;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_GOAL   = 2'd1;
    localparam logic [1:0] ACT_ENABLE = 2'd2;

    localparam logic signed [17:0] PI_Q12     = 18'sd12868;
    localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
    localparam logic signed [ANG_W-1:0] NEAR_Q12 = 17'sd820;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_ALIGN,
        MODE_FORWARD,
        MODE_HEADING
    } mode_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_YAW_GO,
        ST_YAW_WAIT,
        ST_BRG_GO,
        ST_BRG_WAIT,
        ST_DX,
        ST_DY,
        ST_AR,
        ST_CMP,
        ST_PLAN,
        ST_SQ,
        ST_SQ_DIV,
        ST_SHIFT_DIV,
        ST_Q_WAIT,
        ST_EXP_T,
        ST_EXP_F,
        ST_EXP_R,
        ST_HORN_MUL,
        ST_HORN_DIV,
        ST_HORN_WAIT,
        ST_EXP_END,
        ST_SPD_MUL,
        ST_SPD_FIN,
        ST_G_DIV,
        ST_G_WAIT,
        ST_TRN_MUL,
        ST_TRN_FIN,
        ST_FIN,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic                  start;
        logic [DIV_NW-1:0]     dividend;
        logic [DIV_DW-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIV_NW-1:0]     quot;
    } div_rsp_t;

    typedef struct packed {
        logic                     start;
        logic signed [POS_W-1:0]  y;
        logic signed [POS_W-1:0]  x;
    } cor_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [ANG_W-1:0]  angle;
    } cor_rsp_t;

    function automatic logic [16:0] atan_q16(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd51472;
            5'd1:    v = 17'd30386;
            5'd2:    v = 17'd16055;
            5'd3:    v = 17'd8150;
            5'd4:    v = 17'd4091;
            5'd5:    v = 17'd2047;
            5'd6:    v = 17'd1024;
            5'd7:    v = 17'd512;
            5'd8:    v = 17'd256;
            5'd9:    v = 17'd128;
            5'd10:   v = 17'd64;
            5'd11:   v = 17'd32;
            5'd12:   v = 17'd16;
            5'd13:   v = 17'd8;
            5'd14:   v = 17'd4;
            5'd15:   v = 17'd2;
            5'd16:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [ANG_W-1:0] wrap_angle(input logic signed [17:0] a);
        logic signed [17:0] v;
        v = a;
        if (v > PI_Q12) v = v - TWO_PI_Q12;
        if (v <= -PI_Q12) v = v + TWO_PI_Q12;
        return v[ANG_W-1:0];
    endfunction

endpackage

/* rtl/core/gtp_div.sv */
// Shared restoring divider, one quotient bit per cycle, unsigned.
// Depends on gtp_pkg (request and response structs, widths).
module gtp_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  gtp_pkg::div_req_t req,
    output gtp_pkg::div_rsp_t rsp
);
    import gtp_pkg::*;

    localparam int CW = $clog2(DIV_NW);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW:0]   shifted;
    logic [DIV_DW:0]   diff;
    logic              take;

    always_comb begin
        shifted   = {rem_reg, quo_reg[DIV_NW-1]};
        diff      = shifted - {1'b0, den_reg};
        take      = (shifted >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (busy_reg) begin
            rem_next = take ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
            quo_next = {quo_reg[DIV_NW-2:0], take};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIV_NW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = req.divisor;
            quo_next  = req.dividend;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

/* rtl/core/gtp_cordic.sv */
// Vectoring CORDIC for atan2, one micro-rotation per cycle, Q12 angle out.
// Depends on gtp_pkg (structs, angle table).
module gtp_cordic #(
    parameter int STEPS = gtp_pkg::CORDIC_STEPS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  gtp_pkg::cor_req_t req,
    output gtp_pkg::cor_rsp_t rsp
);
    import gtp_pkg::*;

    localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int XW = 40;
    localparam int ZW = 20;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic signed [XW-1:0]    x_reg, x_next, y_reg, y_next;
    logic signed [XW-1:0]    xs, ys, x0, y0;
    logic signed [ZW-1:0]    z_reg, z_next, z_step, tab;
    logic signed [ZW:0]      z_rnd;
    logic signed [ANG_W-1:0] ang_reg, ang_next;

    always_comb begin
        x0        = {{(XW-POS_W-16){req.x[POS_W-1]}}, req.x, 16'b0};
        y0        = {{(XW-POS_W-16){req.y[POS_W-1]}}, req.y, 16'b0};
        xs        = x_reg >>> cnt_reg;
        ys        = y_reg >>> cnt_reg;
        tab       = {3'b000, atan_q16(5'(cnt_reg))};
        z_step    = z_reg;
        z_rnd     = '0;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        ang_next  = ang_reg;
        if (busy_reg) begin
            if (y_reg > 0) begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_step = z_reg + tab;
            end else begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_step = z_reg - tab;
            end
            z_next   = z_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                z_rnd     = {z_step[ZW-1], z_step} + 21'sd8;
                ang_next  = z_rnd[ZW:4];
            end
        end else if (req.start) begin
            if (req.x == 0 && req.y == 0) begin
                done_next = 1'b1;
                ang_next  = '0;
            end else begin
                busy_next = 1'b1;
                cnt_next  = '0;
                if (req.x < 0) begin
                    if (req.y >= 0) begin
                        x_next = y0;
                        y_next = -x0;
                        z_next = 20'sd102944;
                    end else begin
                        x_next = -y0;
                        y_next = x0;
                        z_next = -20'sd102944;
                    end
                end else begin
                    x_next = x0;
                    y_next = y0;
                    z_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        ang_reg <= ang_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.angle = ang_reg;

endmodule

/* rtl/core/go_to_pose_controller_unit.sv */
// Go-to-pose drive controller top level: sequencer, shared multiplier, config registers.
// Depends on gtp_pkg, gtp_cordic and gtp_div.
//
// Goal, enable and ignored transactions go straight to the done state. A pose tick runs
// two CORDIC passes (yaw, then bearing) plus the distance multiplier steps, then the
// drive step: idle adds nothing, align and final heading run one turn-rate evaluation,
// forward runs a speed and a turn-rate evaluation. Every divide goes to the shared
// divider: each exponential takes seven quotients and each turn rate one more. One
// transaction is worked at a time; a finished result waits in the output register
// while the next transaction is accepted.
module go_to_pose_controller_unit #(
    parameter int CORDIC_STEPS = gtp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_action,
    input  logic                         s_pose_valid,
    input  logic signed [19:0]           s_robot_x,
    input  logic signed [19:0]           s_robot_y,
    input  logic signed [15:0]           s_quat_z,
    input  logic signed [15:0]           s_quat_w,
    input  logic signed [19:0]           s_goal_x_in,
    input  logic signed [19:0]           s_goal_y_in,
    input  logic signed [14:0]           s_goal_heading_in,
    input  logic                         s_enable_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_twist_valid,
    output logic [14:0]                  m_linear_velocity,
    output logic signed [15:0]           m_angular_velocity,
    output logic                         m_success_valid,
    output logic                         m_success_flag,
    output logic [1:0]                   m_drive_mode,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [gtp_pkg::CFG_DW-1:0]   cfg_data
);
    import gtp_pkg::*;

    seq_state_t state_reg, state_next;
    mode_t      mode_reg, mode_next;

    logic        enabled_reg, enabled_next;
    logic        pending_reg, pending_next;
    logic        go_reg, go_next;
    logic        sv_reg, sv_next;
    logic        sf_reg, sf_next;
    logic        arrived_reg, arrived_next;
    logic        spd_op_reg, spd_op_next;
    logic        neg_reg, neg_next;

    logic [14:0] mls_reg, mls_next;
    logic [14:0] mtr_reg, mtr_next;
    logic [14:0] sw_reg, sw_next;
    logic [14:0] ts_reg, ts_next;
    logic [18:0] arr_reg, arr_next;

    logic signed [19:0] goal_x_reg, goal_x_next;
    logic signed [19:0] goal_y_reg, goal_y_next;
    logic signed [14:0] goal_h_reg, goal_h_next;
    logic [14:0]        held_lin_reg, held_lin_next;
    logic [15:0]        held_ang_reg, held_ang_next;

    logic signed [POS_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [15:0]      qz_reg, qz_next, qw_reg, qw_next;
    logic signed [ANG_W-1:0] yaw_reg, yaw_next, err_reg, err_next, errh_reg, errh_next;
    logic [POS_W-1:0]        dxm_reg, dxm_next, dym_reg, dym_next;
    logic [41:0]             d2_reg, d2_next;
    logic [ANG_W-1:0]        arg_reg, arg_next;
    logic [31:0]             q_reg, q_next;
    logic [4:0]              n_reg, n_next;
    logic [15:0]             r_reg, r_next;
    logic [16:0]             p_reg, p_next;
    logic [2:0]              k_reg, k_next;
    logic [16:0]             ex_reg, ex_next;
    logic [16:0]             g_reg, g_next;

    logic [31:0] mul_a;
    logic [20:0] mul_b;
    logic [52:0] prod_reg, prod_next;
    logic [52:0] rnd_sum;
    logic [15:0] turn_mag;
    logic signed [ANG_W-1:0] arg_sel;

    logic        m_valid_reg, m_valid_next;
    logic        m_tw_reg, m_tw_next;
    logic [14:0] m_lin_reg, m_lin_next;
    logic [15:0] m_ang_reg, m_ang_next;
    logic        m_sv_reg, m_sv_next;
    logic        m_sf_reg, m_sf_next;
    logic [1:0]  m_mode_reg, m_mode_next;

    logic     accept;
    logic     out_free;
    logic     err_near, errh_near;
    mode_t    mode_eff;
    div_req_t div_req;
    div_rsp_t div_rsp;
    cor_req_t cor_req;
    cor_rsp_t cor_rsp;

    gtp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cor_req),
        .rsp     (cor_rsp)
    );

    gtp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign mode_eff = enabled_reg ? mode_reg : MODE_IDLE;
    assign err_near  = (err_reg < NEAR_Q12) && (err_reg > -NEAR_Q12);
    assign errh_near = (errh_reg < NEAR_Q12) && (errh_reg > -NEAR_Q12);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_action == ACT_TICK && s_pose_valid) state_next = ST_YAW_GO;
                    else state_next = ST_DONE;
                end
            end
            ST_YAW_GO:   state_next = ST_YAW_WAIT;
            ST_YAW_WAIT: if (cor_rsp.done) state_next = ST_BRG_GO;
            ST_BRG_GO:   state_next = ST_BRG_WAIT;
            ST_BRG_WAIT: if (cor_rsp.done) state_next = ST_DX;
            ST_DX:       state_next = ST_DY;
            ST_DY:       state_next = ST_AR;
            ST_AR:       state_next = ST_CMP;
            ST_CMP:      state_next = ST_PLAN;
            ST_PLAN: begin
                case (mode_eff)
                    MODE_IDLE:    state_next = ST_DONE;
                    MODE_FORWARD: state_next = ST_SQ;
                    default:      state_next = ST_SHIFT_DIV;
                endcase
            end
            ST_SQ:        state_next = ST_SQ_DIV;
            ST_SQ_DIV:    state_next = ST_Q_WAIT;
            ST_SHIFT_DIV: state_next = ST_Q_WAIT;
            ST_Q_WAIT:    if (div_rsp.done) state_next = ST_EXP_T;
            ST_EXP_T:     state_next = ST_EXP_F;
            ST_EXP_F:     state_next = ST_EXP_R;
            ST_EXP_R:     state_next = ST_HORN_MUL;
            ST_HORN_MUL:  state_next = ST_HORN_DIV;
            ST_HORN_DIV:  state_next = ST_HORN_WAIT;
            ST_HORN_WAIT: begin
                if (div_rsp.done) state_next = (k_reg == 3'd1) ? ST_EXP_END : ST_HORN_MUL;
            end
            ST_EXP_END:   state_next = spd_op_reg ? ST_SPD_MUL : ST_G_DIV;
            ST_SPD_MUL:   state_next = ST_SPD_FIN;
            ST_SPD_FIN:   state_next = ST_SHIFT_DIV;
            ST_G_DIV:     state_next = ST_G_WAIT;
            ST_G_WAIT:    if (div_rsp.done) state_next = ST_TRN_MUL;
            ST_TRN_MUL:   state_next = ST_TRN_FIN;
            ST_TRN_FIN:   state_next = ST_FIN;
            ST_FIN:       state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        mode_next     = mode_reg;
        enabled_next  = enabled_reg;
        pending_next  = pending_reg;
        go_next       = go_reg;
        sv_next       = sv_reg;
        sf_next       = sf_reg;
        arrived_next  = arrived_reg;
        spd_op_next   = spd_op_reg;
        neg_next      = neg_reg;
        mls_next      = mls_reg;
        mtr_next      = mtr_reg;
        sw_next       = sw_reg;
        ts_next       = ts_reg;
        arr_next      = arr_reg;
        goal_x_next   = goal_x_reg;
        goal_y_next   = goal_y_reg;
        goal_h_next   = goal_h_reg;
        held_lin_next = held_lin_reg;
        held_ang_next = held_ang_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        qz_next       = qz_reg;
        qw_next       = qw_reg;
        yaw_next      = yaw_reg;
        err_next      = err_reg;
        errh_next     = errh_reg;
        dxm_next      = dxm_reg;
        dym_next      = dym_reg;
        d2_next       = d2_reg;
        arg_next      = arg_reg;
        q_next        = q_reg;
        n_next        = n_reg;
        r_next        = r_reg;
        p_next        = p_reg;
        k_next        = k_reg;
        ex_next       = ex_reg;
        g_next        = g_reg;
        m_valid_next  = m_valid_reg;
        m_tw_next     = m_tw_reg;
        m_lin_next    = m_lin_reg;
        m_ang_next    = m_ang_reg;
        m_sv_next     = m_sv_reg;
        m_sf_next     = m_sf_reg;
        m_mode_next   = m_mode_reg;
        mul_a         = '0;
        mul_b         = '0;
        arg_sel       = err_reg;
        rnd_sum       = prod_reg + 53'd32768;
        turn_mag      = (|rnd_sum[52:31]) ? 16'd32767 : {1'b0, rnd_sum[30:16]};
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = 18'd1;
        cor_req.start = 1'b0;
        cor_req.y     = dy_reg;
        cor_req.x     = dx_reg;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        if (cfg_we) begin
            case (cfg_index)
                CFG_MAX_LIN:    mls_next = cfg_data[14:0];
                CFG_MAX_TURN:   mtr_next = cfg_data[14:0];
                CFG_SPD_WIDTH:  sw_next  = cfg_data[14:0];
                CFG_TURN_SLOPE: ts_next  = cfg_data[14:0];
                CFG_ARRIVE:     arr_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    go_next = 1'b0;
                    sv_next = 1'b0;
                    sf_next = 1'b0;
                    case (s_action)
                        ACT_GOAL: begin
                            sv_next      = 1'b1;
                            pending_next = 1'b1;
                            enabled_next = 1'b1;
                            goal_x_next  = s_goal_x_in;
                            goal_y_next  = s_goal_y_in;
                            goal_h_next  = s_goal_heading_in;
                        end
                        ACT_ENABLE: enabled_next = s_enable_value;
                        ACT_TICK: begin
                            go_next = s_pose_valid;
                            dx_next = {goal_x_reg[19], goal_x_reg} - {s_robot_x[19], s_robot_x};
                            dy_next = {goal_y_reg[19], goal_y_reg} - {s_robot_y[19], s_robot_y};
                            qz_next = s_quat_z;
                            qw_next = s_quat_w;
                        end
                        default: ;
                    endcase
                end
            end
            ST_YAW_GO: begin
                cor_req.start = 1'b1;
                cor_req.y     = {{(POS_W-16){qz_reg[15]}}, qz_reg};
                cor_req.x     = {{(POS_W-16){qw_reg[15]}}, qw_reg};
            end
            ST_YAW_WAIT: begin
                if (cor_rsp.done) yaw_next = wrap_angle({cor_rsp.angle, 1'b0});
            end
            ST_BRG_GO: cor_req.start = 1'b1;
            ST_BRG_WAIT: begin
                if (cor_rsp.done) begin
                    err_next  = wrap_angle({cor_rsp.angle[ANG_W-1], cor_rsp.angle}
                                           - {yaw_reg[ANG_W-1], yaw_reg});
                    errh_next = wrap_angle({{3{goal_h_reg[14]}}, goal_h_reg}
                                           - {yaw_reg[ANG_W-1], yaw_reg});
                    dxm_next  = dx_reg[POS_W-1] ? -dx_reg : dx_reg;
                    dym_next  = dy_reg[POS_W-1] ? -dy_reg : dy_reg;
                end
            end
            ST_DX: begin
                mul_a = 32'(dxm_reg);
                mul_b = dxm_reg;
            end
            ST_DY: begin
                d2_next = prod_reg[41:0];
                mul_a   = 32'(dym_reg);
                mul_b   = dym_reg;
            end
            ST_AR: begin
                d2_next = d2_reg + prod_reg[41:0];
                mul_a   = 32'(arr_reg);
                mul_b   = 21'(arr_reg);
            end
            ST_CMP: arrived_next = (d2_reg < prod_reg[41:0]);
            ST_PLAN: begin
                mode_next = mode_eff;
                arg_sel   = (mode_eff == MODE_HEADING) ? errh_reg : err_reg;
                arg_next  = arg_sel[ANG_W-1] ? (-arg_sel) : arg_sel;
                neg_next  = arg_sel[ANG_W-1];
                if (mode_eff == MODE_IDLE) begin
                    if (pending_reg) begin
                        mode_next    = MODE_ALIGN;
                        pending_next = 1'b0;
                    end else begin
                        go_next = 1'b0;
                    end
                end
                if (mode_eff == MODE_HEADING) held_lin_next = '0;
            end
            ST_SQ: begin
                spd_op_next = 1'b1;
                mul_a       = 32'(arg_reg);
                mul_b       = 21'(arg_reg);
            end
            ST_SQ_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg[DIV_NW-1:0];
                div_req.divisor  = (sw_reg == '0) ? 18'd1 : 18'(sw_reg);
            end
            ST_SHIFT_DIV: begin
                spd_op_next      = 1'b0;
                div_req.start    = 1'b1;
                div_req.dividend = DIV_NW'({arg_reg, 12'b0});
                div_req.divisor  = (ts_reg == '0) ? 18'd1 : 18'(ts_reg);
            end
            ST_Q_WAIT: if (div_rsp.done) q_next = div_rsp.quot[31:0];
            ST_EXP_T: begin
                mul_a = q_reg;
                mul_b = 21'd94548;
            end
            ST_EXP_F: begin
                n_next = (prod_reg[52:28] >= 25'd17) ? 5'd17 : prod_reg[32:28];
                mul_a  = 32'(prod_reg[27:12]);
                mul_b  = 21'd45426;
            end
            ST_EXP_R: begin
                r_next = prod_reg[31:16];
                p_next = 17'd65536;
                k_next = 3'd6;
            end
            ST_HORN_MUL: begin
                mul_a = 32'(r_reg);
                mul_b = 21'(p_reg);
            end
            ST_HORN_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_NW'(prod_reg[32:16]);
                div_req.divisor  = 18'(k_reg);
            end
            ST_HORN_WAIT: begin
                if (div_rsp.done) begin
                    p_next = 17'd65536 - div_rsp.quot[16:0];
                    k_next = k_reg - 3'd1;
                end
            end
            ST_EXP_END: ex_next = (n_reg >= 5'd17) ? 17'd0 : (p_reg >> n_reg);
            ST_SPD_MUL: begin
                mul_a = 32'(mls_reg);
                mul_b = 21'(ex_reg);
            end
            ST_SPD_FIN: held_lin_next = rnd_sum[30:16];
            ST_G_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = {17'd65536 - ex_reg, 16'b0};
                div_req.divisor  = 18'd65536 + 18'(ex_reg);
            end
            ST_G_WAIT: if (div_rsp.done) g_next = div_rsp.quot[16:0];
            ST_TRN_MUL: begin
                mul_a = 32'(mtr_reg);
                mul_b = 21'(g_reg);
            end
            ST_TRN_FIN: held_ang_next = neg_reg ? (16'd0 - turn_mag) : turn_mag;
            ST_FIN: begin
                case (mode_reg)
                    MODE_ALIGN:   if (err_near) mode_next = MODE_FORWARD;
                    MODE_FORWARD: if (arrived_reg) mode_next = MODE_HEADING;
                    MODE_HEADING: begin
                        if (errh_near) begin
                            sv_next      = 1'b1;
                            sf_next      = 1'b1;
                            mode_next    = MODE_IDLE;
                            enabled_next = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_tw_next    = go_reg && enabled_reg;
                    m_lin_next   = (go_reg && enabled_reg) ? held_lin_reg : '0;
                    m_ang_next   = (go_reg && enabled_reg) ? held_ang_reg : '0;
                    m_sv_next    = sv_reg;
                    m_sf_next    = sv_reg && sf_reg;
                    m_mode_next  = mode_reg;
                end
            end
            default: ;
        endcase

        prod_next = 53'(mul_a) * 53'(mul_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_IDLE;
            enabled_reg  <= 1'b0;
            pending_reg  <= 1'b0;
            go_reg       <= 1'b0;
            sv_reg       <= 1'b0;
            sf_reg       <= 1'b0;
            mls_reg      <= 15'd1229;
            mtr_reg      <= 15'd4096;
            sw_reg       <= 15'd1229;
            ts_reg       <= 15'd1229;
            arr_reg      <= 19'd2048;
            goal_x_reg   <= '0;
            goal_y_reg   <= '0;
            goal_h_reg   <= '0;
            held_lin_reg <= '0;
            held_ang_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            enabled_reg  <= enabled_next;
            pending_reg  <= pending_next;
            go_reg       <= go_next;
            sv_reg       <= sv_next;
            sf_reg       <= sf_next;
            mls_reg      <= mls_next;
            mtr_reg      <= mtr_next;
            sw_reg       <= sw_next;
            ts_reg       <= ts_next;
            arr_reg      <= arr_next;
            goal_x_reg   <= goal_x_next;
            goal_y_reg   <= goal_y_next;
            goal_h_reg   <= goal_h_next;
            held_lin_reg <= held_lin_next;
            held_ang_reg <= held_ang_next;
            m_valid_reg  <= m_valid_next;
        end
        arrived_reg <= arrived_next;
        spd_op_reg  <= spd_op_next;
        neg_reg     <= neg_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        qz_reg      <= qz_next;
        qw_reg      <= qw_next;
        yaw_reg     <= yaw_next;
        err_reg     <= err_next;
        errh_reg    <= errh_next;
        dxm_reg     <= dxm_next;
        dym_reg     <= dym_next;
        d2_reg      <= d2_next;
        arg_reg     <= arg_next;
        q_reg       <= q_next;
        n_reg       <= n_next;
        r_reg       <= r_next;
        p_reg       <= p_next;
        k_reg       <= k_next;
        ex_reg      <= ex_next;
        g_reg       <= g_next;
        prod_reg    <= prod_next;
        m_tw_reg    <= m_tw_next;
        m_lin_reg   <= m_lin_next;
        m_ang_reg   <= m_ang_next;
        m_sv_reg    <= m_sv_next;
        m_sf_reg    <= m_sf_next;
        m_mode_reg  <= m_mode_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_twist_valid      = m_tw_reg;
    assign m_linear_velocity  = m_lin_reg;
    assign m_angular_velocity = m_ang_reg;
    assign m_success_valid    = m_sv_reg;
    assign m_success_flag     = m_sf_reg;
    assign m_drive_mode       = m_mode_reg;

    // success leaves the controller disabled and idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && sf_reg) |-> (!enabled_reg && mode_reg == MODE_IDLE))
        else $error("success transaction without disable");

    // no velocity is reported without a twist
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_twist_valid) |-> (m_linear_velocity == '0 && m_angular_velocity == '0))
        else $error("velocity reported without twist");

    // series divisor stays within its term range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HORN_DIV) |-> (k_reg >= 3'd1 && k_reg <= 3'd6))
        else $error("series term out of range");

    // a quotient is only consumed after a divide was started
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_Q_WAIT && $past(state_reg) != ST_Q_WAIT) |->
        ($past(state_reg) == ST_SQ_DIV || $past(state_reg) == ST_SHIFT_DIV))
        else $error("quotient wait entered without divide");

endmodule

/* bench/go_to_pose_controller_unit_test.sv */
// Self-checking bench for go_to_pose_controller_unit: drives goal, enable and pose
// transactions with random idling, predicts each result and checks it at the output.
// Depends on gtp_pkg and the go_to_pose_controller_unit RTL.
module go_to_pose_controller_unit_test;
    import gtp_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int CORDIC_N = 16;
    localparam longint PI_V = 12868;
    localparam longint TWO_PI_V = 25736;
    localparam real PI_R = 3.14159265358979;

    typedef struct {
        logic [1:0]         action;
        logic               pose_valid;
        logic signed [19:0] rx;
        logic signed [19:0] ry;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic signed [19:0] gx;
        logic signed [19:0] gy;
        logic signed [14:0] gh;
        logic               en;
    } pose_cmd_t;

    typedef struct {
        logic               tw;
        logic [14:0]        lin;
        logic signed [15:0] ang;
        logic               sv;
        logic               sf;
        logic [1:0]         mode;
    } drive_cmd_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [1:0] s_action = 0;
    logic s_pose_valid = 0;
    logic signed [19:0] s_robot_x = 0, s_robot_y = 0, s_goal_x_in = 0, s_goal_y_in = 0;
    logic signed [15:0] s_quat_z = 0, s_quat_w = 0;
    logic signed [14:0] s_goal_heading_in = 0;
    logic s_enable_value = 0;
    logic m_valid;
    logic m_ready = 0;
    logic m_twist_valid;
    logic [14:0] m_linear_velocity;
    logic signed [15:0] m_angular_velocity;
    logic m_success_valid, m_success_flag;
    logic [1:0] m_drive_mode;
    logic cfg_we = 0;
    logic [2:0] cfg_index = 0;
    logic [CFG_DW-1:0] cfg_data = 0;

    go_to_pose_controller_unit DUT (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predictor state
    longint cfg_lin = 1229, cfg_turn = 4096, cfg_sw = 1229, cfg_ts = 1229, cfg_arr = 2048;
    mode_t  p_mode = MODE_IDLE;
    bit     p_enabled = 0, p_pending = 0;
    longint p_gx = 0, p_gy = 0, p_gh = 0, p_lin = 0, p_ang = 0;
    longint atan_q16_tab [24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                  256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

    pose_cmd_t  pending_q[$];
    drive_cmd_t expected_q[$];
    pose_cmd_t  cur_cmd;
    int  acc_cnt = 0, drv_cnt = 0, errors = 0, gap = 0, rgap = 0, hold_cnt = 0;
    bit  hold_done = 0, calm = 0;

    function automatic longint wrap_ang(longint a);
        if (a > PI_V) a -= TWO_PI_V;
        if (a <= -PI_V) a += TWO_PI_V;
        return a;
    endfunction

    function automatic longint atan2_fix(longint y, longint x);
        longint z, t, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        x *= 65536;
        y *= 65536;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 102944;
            end else begin
                t = x; x = -y; y = t; z = -102944;
            end
        end
        for (int i = 0; i < CORDIC_N; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += atan_q16_tab[i];
            end else begin
                x -= ys; y += xs; z -= atan_q16_tab[i];
            end
        end
        return (z + 8) >>> 4;
    endfunction

    function automatic longint exp_decay(longint q);
        longint t, n, f, r, p;
        p = 65536;
        if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
        t = (q * 94548) >> 12;
        n = t >> 16;
        f = t & 16'hFFFF;
        if (n >= 17) return 0;
        r = (f * 45426) >> 16;
        for (int k = 6; k >= 1; k--) p = 65536 - ((r * p) >> 16) / k;
        return p >> n;
    endfunction

    function automatic longint speed_for(longint e);
        longint a, d;
        a = (e < 0) ? -e : e;
        d = cfg_sw ? cfg_sw : 1;
        return (cfg_lin * exp_decay((a * a) / d) + 32768) >> 16;
    endfunction

    function automatic longint turn_for(longint e);
        longint a, d, ex, g, m;
        a = (e < 0) ? -e : e;
        d = cfg_ts ? cfg_ts : 1;
        ex = exp_decay((a << 12) / d);
        g = ((65536 - ex) << 16) / (65536 + ex);
        m = (cfg_turn * g + 32768) >> 16;
        if (m > 32767) m = 32767;
        return (e < 0) ? -m : m;
    endfunction

    function automatic bit aligned(longint e);
        return ((e < 0) ? -e : e) < 820;
    endfunction

    function automatic drive_cmd_t drive_step(pose_cmd_t c);
        drive_cmd_t r;
        longint yaw, dx, dy, e, eh, vel, w;
        bit arrived, go;
        r = '{default: 0};
        if (c.action == ACT_GOAL) begin
            r.sv = 1;
            p_pending = 1;
            p_enabled = 1;
            p_gx = c.gx;
            p_gy = c.gy;
            p_gh = c.gh;
        end else if (c.action == ACT_ENABLE) begin
            p_enabled = c.en;
        end else if (c.action == ACT_TICK && c.pose_valid) begin
            yaw = wrap_ang(2 * atan2_fix(c.qz, c.qw));
            dx = p_gx - c.rx;
            dy = p_gy - c.ry;
            arrived = (dx * dx + dy * dy) < cfg_arr * cfg_arr;
            e = wrap_ang(atan2_fix(dy, dx) - yaw);
            vel = speed_for(e);
            w = turn_for(e);
            go = 1;
            if (!p_enabled) p_mode = MODE_IDLE;
            case (p_mode)
                MODE_IDLE: begin
                    if (p_pending) begin
                        p_mode = MODE_ALIGN;
                        p_pending = 0;
                    end else go = 0;
                end
                MODE_ALIGN: begin
                    p_ang = w;
                    if (aligned(e)) p_mode = MODE_FORWARD;
                end
                MODE_FORWARD: begin
                    p_lin = vel;
                    p_ang = w;
                    if (arrived) p_mode = MODE_HEADING;
                end
                default: begin
                    eh = wrap_ang(p_gh - yaw);
                    p_lin = 0;
                    if (aligned(eh)) begin
                        r.sv = 1;
                        r.sf = 1;
                        p_mode = MODE_IDLE;
                        p_enabled = 0;
                    end
                    p_ang = turn_for(eh);
                end
            endcase
            if (go && p_enabled) begin
                r.tw = 1;
                r.lin = p_lin[14:0];
                r.ang = p_ang[15:0];
            end
        end
        r.mode = p_mode;
        return r;
    endfunction

    task automatic report(string field, longint got, longint want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d", field, got, want);
    endtask

    // driver
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || acc_cnt == drv_cnt)) begin
            if (gap > 0) begin
                gap--;
                s_valid <= 0;
            end else if (pending_q.size() > 0) begin
                cur_cmd = pending_q.pop_front();
                s_action <= cur_cmd.action;
                s_pose_valid <= cur_cmd.pose_valid;
                s_robot_x <= cur_cmd.rx;
                s_robot_y <= cur_cmd.ry;
                s_quat_z <= cur_cmd.qz;
                s_quat_w <= cur_cmd.qw;
                s_goal_x_in <= cur_cmd.gx;
                s_goal_y_in <= cur_cmd.gy;
                s_goal_heading_in <= cur_cmd.gh;
                s_enable_value <= cur_cmd.en;
                s_valid <= 1;
                drv_cnt++;
                if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
            end else begin
                s_valid <= 0;
            end
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(negedge aclk) begin
        if (!hold_done && acc_cnt >= 60) begin
            hold_done = 1;
            hold_cnt = 3000;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 0;
        end else if (calm) begin
            m_ready <= 1;
        end else if (rgap > 0) begin
            rgap--;
            m_ready <= 0;
        end else begin
            m_ready <= 1;
            if ($urandom_range(0, 4) == 0) rgap = $urandom_range(1, 5);
        end
    end

    // monitor
    always @(posedge aclk) begin
        drive_cmd_t want;
        if (aresetn && s_valid && s_ready) begin
            expected_q.push_back(drive_step(cur_cmd));
            acc_cnt++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report("unexpected transaction", 1, 0);
            end else begin
                want = expected_q.pop_front();
                if (m_twist_valid !== want.tw) report("twist_valid", m_twist_valid, want.tw);
                if (m_linear_velocity !== want.lin)
                    report("linear_velocity", m_linear_velocity, want.lin);
                if (m_angular_velocity !== want.ang)
                    report("angular_velocity", m_angular_velocity, want.ang);
                if (m_success_valid !== want.sv)
                    report("success_valid", m_success_valid, want.sv);
                if (m_success_flag !== want.sf) report("success_flag", m_success_flag, want.sf);
                if (m_drive_mode !== want.mode) report("drive_mode", m_drive_mode, want.mode);
            end
        end
    end

    function automatic pose_cmd_t noise_cmd();
        pose_cmd_t c;
        c.action = $urandom;
        c.pose_valid = $urandom;
        c.rx = $urandom;
        c.ry = $urandom;
        c.qz = $urandom;
        c.qw = $urandom;
        c.gx = $urandom;
        c.gy = $urandom;
        c.gh = $urandom;
        c.en = $urandom;
        return c;
    endfunction

    function automatic pose_cmd_t tick_cmd(longint rx, longint ry, longint qz, longint qw);
        pose_cmd_t c;
        c = noise_cmd();
        c.action = ACT_TICK;
        c.pose_valid = 1;
        c.rx = rx;
        c.ry = ry;
        c.qz = qz;
        c.qw = qw;
        return c;
    endfunction

    function automatic pose_cmd_t yaw_tick(longint rx, longint ry, real yaw);
        return tick_cmd(rx, ry, $rtoi($floor(16384.0 * $sin(yaw / 2.0) + 0.5)),
                        $rtoi($floor(16384.0 * $cos(yaw / 2.0) + 0.5)));
    endfunction

    function automatic pose_cmd_t goal_cmd(longint gx, longint gy, longint gh);
        pose_cmd_t c;
        c = noise_cmd();
        c.action = ACT_GOAL;
        c.gx = gx;
        c.gy = gy;
        c.gh = gh;
        return c;
    endfunction

    function automatic pose_cmd_t enable_cmd(bit v);
        pose_cmd_t c;
        c = noise_cmd();
        c.action = ACT_ENABLE;
        c.en = v;
        return c;
    endfunction

    function automatic real jitter(real span);
        return span * ($urandom_range(0, 2000) - 1000) / 1000.0;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [CFG_DW-1:0] val);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_MAX_LIN:    cfg_lin  = val & 15'h7FFF;
            CFG_MAX_TURN:   cfg_turn = val & 15'h7FFF;
            CFG_SPD_WIDTH:  cfg_sw   = val & 15'h7FFF;
            CFG_TURN_SLOPE: cfg_ts   = val & 15'h7FFF;
            CFG_ARRIVE:     cfg_arr  = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    task automatic write_all(longint a, longint b, longint c, longint d, longint e);
        write_reg(CFG_MAX_LIN, a);
        write_reg(CFG_MAX_TURN, b);
        write_reg(CFG_SPD_WIDTH, c);
        write_reg(CFG_TURN_SLOPE, d);
        write_reg(CFG_ARRIVE, e);
    endtask

    // goal, misaligned ticks, aligned ticks, drive in, arrive, settle heading
    task automatic push_approach();
        longint gx, gy, gh, rx, ry;
        real b, h;
        gx = $urandom_range(0, 600000) - 300000;
        gy = $urandom_range(0, 600000) - 300000;
        gh = $urandom_range(0, 25736) - 12868;
        rx = gx + $urandom_range(0, 80000) - 40000;
        ry = gy + $urandom_range(0, 80000) - 40000;
        h = gh / 4096.0;
        pending_q.push_back(goal_cmd(gx, gy, gh));
        repeat ($urandom_range(1, 2)) pending_q.push_back(yaw_tick(rx, ry, jitter(PI_R)));
        b = $atan2(real'(gy - ry), real'(gx - rx));
        repeat (2) pending_q.push_back(yaw_tick(rx, ry, b + jitter(0.1)));
        if ($urandom_range(0, 5) == 0) pending_q.push_back(noise_cmd());
        rx = (rx + gx) / 2;
        ry = (ry + gy) / 2;
        repeat (2) pending_q.push_back(yaw_tick(rx, ry, b + jitter(0.3)));
        rx = gx + $urandom_range(0, 1200) - 600;
        ry = gy + $urandom_range(0, 1200) - 600;
        repeat (2) pending_q.push_back(yaw_tick(rx, ry, b + jitter(0.2)));
        if ($urandom_range(0, 5) == 0) pending_q.push_back(enable_cmd($urandom));
        pending_q.push_back(yaw_tick(rx, ry, h + jitter(1.0)));
        repeat (2) pending_q.push_back(yaw_tick(rx, ry, h + jitter(0.15)));
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || acc_cnt != drv_cnt || expected_q.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic random_phase(int count);
        int start;
        start = pending_q.size() + drv_cnt;
        while (pending_q.size() + drv_cnt - start < count) begin
            if ($urandom_range(0, 4) == 0) pending_q.push_back(noise_cmd());
            else push_approach();
        end
        drain();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        write_all(1229, 4096, 1229, 1229, 2048);

        // directed: idle without goal, missing pose, unknown action, extremes
        pending_q.push_back(tick_cmd(0, 0, 0, 16384));
        begin
            pose_cmd_t c;
            c = tick_cmd(1000, 1000, 0, 16384);
            c.pose_valid = 0;
            pending_q.push_back(c);
            c = noise_cmd();
            c.action = ACT_NONE;
            pending_q.push_back(c);
        end
        pending_q.push_back(goal_cmd(0, 0, 0));
        pending_q.push_back(tick_cmd(-524288, -524288, 16384, 0));
        pending_q.push_back(tick_cmd(524287, 524287, -16384, 0));
        pending_q.push_back(tick_cmd(524287, -524288, 0, -16384));
        pending_q.push_back(tick_cmd(0, 0, -32768, 32767));
        pending_q.push_back(goal_cmd(524287, -524288, -16384));
        pending_q.push_back(tick_cmd(-524288, 524287, 32767, -32768));
        pending_q.push_back(tick_cmd(0, 0, 0, 0));
        pending_q.push_back(enable_cmd(0));
        pending_q.push_back(tick_cmd(100, 100, 0, 16384));
        pending_q.push_back(enable_cmd(1));
        pending_q.push_back(tick_cmd(100, 100, 0, 16384));
        pending_q.push_back(goal_cmd(-524288, 524287, 16383));
        pending_q.push_back(tick_cmd(-524288, 524287, 0, 16384));
        pending_q.push_back(tick_cmd(-524288, 524287, 11585, 11585));
        pending_q.push_back(goal_cmd(4096, 0, 12868));
        pending_q.push_back(tick_cmd(0, 0, 0, 16384));
        pending_q.push_back(tick_cmd(0, 0, 0, 16384));
        pending_q.push_back(tick_cmd(4000, 0, 0, 16384));
        pending_q.push_back(tick_cmd(4096, 0, 16384, 0));
        drain();

        random_phase(160);
        write_all(32767, 32767, 32767, 32767, 524287);
        random_phase(130);
        write_all(0, 0, 0, 0, 0);
        random_phase(100);
        write_all($urandom, $urandom, $urandom, $urandom, $urandom);
        random_phase(130);
        write_all($urandom_range(0, 32767), $urandom_range(0, 32767),
                  $urandom_range(1, 4096), $urandom_range(1, 4096),
                  $urandom_range(1024, 8192));
        random_phase(130);
        calm = 1;
        write_all(1229, 4096, 1229, 1229, 2048);
        random_phase(150);

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #30000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
